/* hdl/ldt_pkg.sv */
// types and constants of the local descriptor table writer
// no dependencies; used by every module of the block
package ldt_pkg;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic StatusOk    = 1'b0;
  localparam logic StatusInval = 1'b1;

  localparam logic [1:0] ContData     = 2'd0;
  localparam logic [1:0] ContConfCode = 2'd3;

  localparam logic [15:0] ReqBytes = 16'd16;

  // request item
  typedef struct packed {
    logic        operation;
    logic        legacy;
    logic [15:0] byte_count;
    logic [13:0] entry_index;
    logic [31:0] seg_base;
    logic [19:0] seg_limit;
    logic        is_32bit;
    logic [1:0]  contents;
    logic        type_ro;
    logic        page_gran;
    logic        not_present;
    logic        usable;
  } in_t;

  // result item
  typedef struct packed {
    logic        status;
    logic [63:0] descriptor;
    logic [13:0] count_now;
  } out_t;

  // classified command between front and back
  typedef struct packed {
    logic        is_write;
    logic        bad;
    logic [13:0] idx;
    logic [63:0] desc;
  } cmd_t;

endpackage

/* hdl/ldt_front.sv */
// front end: checks a request and packs the descriptor
// uses ldt_pkg
module ldt_front #(
  parameter int ENTRIES = 8192
) (
  input  ldt_pkg::in_t  req_i,
  output ldt_pkg::cmd_t cmd_o
);

  localparam logic [14:0] EntriesW = 15'(ENTRIES);

  logic       bad_pre;
  logic       empty;
  logic       bad;
  logic [3:0] seg_type;
  logic       avl;

  always_comb begin
    bad_pre = (req_i.byte_count != ldt_pkg::ReqBytes)
           || ({1'b0, req_i.entry_index} >= EntriesW)
           || ((req_i.contents == ldt_pkg::ContConfCode)
               && (req_i.legacy || !req_i.not_present));
    empty = (req_i.seg_base == 32'd0) && (req_i.seg_limit == 20'd0)
         && (req_i.legacy
             || ((req_i.contents == ldt_pkg::ContData) && req_i.type_ro
                 && !req_i.page_gran && req_i.not_present && !req_i.usable));
    bad      = bad_pre || (!empty && !req_i.is_32bit);
    seg_type = {req_i.contents, !req_i.type_ro, 1'b1};
    avl      = req_i.usable && !req_i.legacy;

    cmd_o.is_write = (req_i.operation == ldt_pkg::OpWrite);
    cmd_o.bad      = bad;
    cmd_o.idx      = req_i.entry_index;
    if (bad || empty) begin
      cmd_o.desc = 64'd0;
    end else begin
      cmd_o.desc = {req_i.seg_base[31:24], req_i.page_gran, req_i.is_32bit,
                    1'b0, avl, req_i.seg_limit[19:16], !req_i.not_present,
                    2'b11, 1'b1, seg_type, req_i.seg_base[23:0],
                    req_i.seg_limit[15:0]};
    end
  end

endmodule

/* hdl/ldt_queue.sv */
// two-entry queue of classified commands between front and back
// uses ldt_pkg
module ldt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ldt_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ldt_pkg::cmd_t pop_data_o
);

  ldt_pkg::cmd_t slot_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    fill_q, fill_d;

  assign full_o     = fill_q[1];
  assign valid_o    = (fill_q != 2'd0);
  assign pop_data_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/ldt_back.sv */
// back end: table memory, entry count, result stage and output register
// uses ldt_pkg
module ldt_back #(
  parameter int ENTRIES = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  ldt_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          clearing_o,
  output logic          out_valid_o,
  output ldt_pkg::out_t out_o,
  input  logic          out_stall_i
);

  localparam int IdxW = $clog2(ENTRIES);
  localparam int CntW = $clog2(ENTRIES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  typedef enum logic [1:0] {
    StClear = 2'b01,
    StRun   = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [CntW-1:0] count_q, count_d;

  logic [63:0]     mem [ENTRIES];
  logic [63:0]     rdata_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_addr;
  logic [63:0]     mem_wdata;

  // result stage waiting on the read data
  logic            s1_valid_q, s1_valid_d;
  logic            s1_status_q;
  logic            s1_use_rd_q;
  logic [63:0]     s1_desc_q;
  logic [13:0]     s1_count_q;

  logic            out_valid_q, out_valid_d;
  ldt_pkg::out_t   out_q;

  logic            out_adv;
  logic            pop;
  logic            wr_ok;
  logic            rd_hit;
  logic [14:0]     idx_w;
  logic [CntW-1:0] idx_next;

  assign clearing_o  = (state_q == StClear);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cmd_pop_o   = pop;

  always_comb begin
    out_adv  = !out_valid_q || !out_stall_i;
    pop      = cmd_valid_i && (state_q == StRun) && (!s1_valid_q || out_adv);
    idx_w    = {1'b0, cmd_i.idx};
    idx_next = CntW'(idx_w + 15'd1);
    wr_ok    = cmd_i.is_write && !cmd_i.bad;
    rd_hit   = !cmd_i.is_write && (idx_w < 15'(count_q));

    state_d = state_q;
    clr_d   = clr_q;
    count_d = count_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cmd_i.idx[IdxW-1:0];
    mem_wdata = cmd_i.desc;

    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = 64'd0;
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == LastIdx) begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (pop) begin
          mem_we = wr_ok;
          mem_re = !cmd_i.is_write;
          if (wr_ok && (idx_next > count_q)) begin
            count_d = idx_next;
          end
        end
      end
      default: state_d = StClear;
    endcase

    if (pop) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end

    if (s1_valid_q && out_adv) begin
      out_valid_d = 1'b1;
    end else if (out_adv) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      count_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_status_q <= (cmd_i.is_write && cmd_i.bad) ? ldt_pkg::StatusInval
                                                   : ldt_pkg::StatusOk;
      s1_use_rd_q <= rd_hit;
      s1_desc_q   <= wr_ok ? cmd_i.desc : 64'd0;
      s1_count_q  <= 14'(count_d);
    end
    if (s1_valid_q && out_adv) begin
      out_q.status     <= s1_status_q;
      out_q.descriptor <= s1_use_rd_q ? rdata_q : s1_desc_q;
      out_q.count_now  <= s1_count_q;
    end
  end

endmodule

/* hdl/ldt_descriptor_table_writer.sv */
// top level of the local descriptor table writer
// uses ldt_pkg, ldt_front, ldt_queue and ldt_back
//
// usage
//   request channel: in_valid_i / in_i / in_stall_o, one transfer is one
//   read or write of a table entry; a write is checked and packed into a
//   64-bit segment descriptor, a read returns the stored entry or zero
//   at or past the count of entries in use
//   result channel: out_valid_o / out_o / out_stall_i, exactly one result
//   transfer per request, in request order
//   order: a request is written into the queue, then takes its table
//   access in the result stage, then reaches the output register
//   throughput: one request per cycle unless stalled; the single-port
//   table does at most one access per request and the read data is registered
//   reset: the table is zeroed by a pass that writes one entry a cycle,
//   all ENTRIES entries (8192 by default); in_stall_o stays high during
//   that pass, and the entry count starts at zero
//   receiver stall: the output register holds its item, the result stage
//   and the two-entry queue fill up, and then in_stall_o rises
module ldt_descriptor_table_writer #(
  parameter int ENTRIES = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ldt_pkg::in_t  in_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output ldt_pkg::out_t out_o,
  input  logic          out_stall_i
);

  ldt_pkg::cmd_t front_cmd;
  ldt_pkg::cmd_t queue_cmd;
  logic          queue_full;
  logic          queue_valid;
  logic          queue_pop;
  logic          clearing;
  logic          push;

  // requests are held off while the queue is full or the table is zeroed
  assign in_stall_o = queue_full || clearing;
  assign push       = in_valid_i && !in_stall_o;

  // request checks and descriptor packing
  ldt_front #(
    .ENTRIES(ENTRIES)
  ) u_front (
    .req_i(in_i),
    .cmd_o(front_cmd)
  );

  // decouples acceptance from table access
  ldt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(front_cmd),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .valid_o    (queue_valid),
    .pop_data_o (queue_cmd)
  );

  // table memory, entry count and result registers
  ldt_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(queue_valid),
    .cmd_i      (queue_cmd),
    .cmd_pop_o  (queue_pop),
    .clearing_o (clearing),
    .out_valid_o(out_valid_o),
    .out_o      (out_o),
    .out_stall_i(out_stall_i)
  );

endmodule
